### design/setrk_pkg.sv
// Package: shared types, register codes and the coil phase table of the stepper axis.
`default_nettype none
package setrk_pkg;

  localparam int unsigned DivSteps  = 16;
  localparam int unsigned DivCntW   = $clog2(DivSteps);

  // Configuration register indexes
  typedef enum logic [2:0] {
    CFG_ERROR_COMPONENT  = 3'd0,
    CFG_INVERT_RESPONSE  = 3'd1,
    CFG_DEADBAND         = 3'd2,
    CFG_MAX_ERROR        = 3'd3,
    CFG_MIN_INTERVAL_MS  = 3'd4,
    CFG_MAX_INTERVAL_MS  = 3'd5,
    CFG_FRAME_STEP_LIMIT = 3'd6
  } cfg_addr_e;

  typedef struct packed {
    logic [31:0]        now_ms;
    logic signed [15:0] yaw_error;
    logic signed [15:0] pitch_error;
    logic               tracking_on;
    logic               new_frame;
  } in_word_t;

  typedef struct packed {
    logic [3:0]  coil_pattern;
    logic        stepped;
    logic        step_backward;
    logic [15:0] interval_ms;
  } out_word_t;

  typedef struct packed {
    logic [2:0]  addr;
    logic [15:0] wdata;
  } cfg_word_t;

  // Half-step coil drive, bit0 is the first coil
  function automatic logic [3:0] coil_of_phase(input logic [2:0] phase);
    logic [3:0] pat;
    unique case (phase)
      3'd0:    pat = 4'h1;
      3'd1:    pat = 4'h3;
      3'd2:    pat = 4'h2;
      3'd3:    pat = 4'h6;
      3'd4:    pat = 4'h4;
      3'd5:    pat = 4'hC;
      3'd6:    pat = 4'h8;
      default: pat = 4'h9;
    endcase
    return pat;
  endfunction

endpackage
`default_nettype wire

### design/setrk_in_if.sv
// Interface: input tick channel (valid/ready with one tick word).
`default_nettype none
interface setrk_in_if import setrk_pkg::*;;
  logic     valid;
  logic     ready;
  in_word_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

### design/setrk_out_if.sv
// Interface: result channel (valid/ready with one result word).
`default_nettype none
interface setrk_out_if import setrk_pkg::*;;
  logic      valid;
  logic      ready;
  out_word_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

### design/setrk_cfg_if.sv
// Interface: configuration write channel (valid/ready with index and write data).
`default_nettype none
interface setrk_cfg_if import setrk_pkg::*;;
  logic      valid;
  logic      ready;
  cfg_word_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

### design/stepper_error_tracking_stepper.sv
// Top level: error-tracking stepper axis with deadband, speed interpolation and frame step cap.
// Per tick: magnitude, then the evaluate step; an interpolated interval runs multiply and
// 16 divide iterations, then step and output load; a fast step skips the divide, others go to output load.
// A new tick is taken only once the previous one has reached the output load.
// A finished result sits in the output register, so the next tick is taken while it waits.
// Reset (rst_ni low, async): configuration registers return to their defaults, phase 0,
// coils off, next step time 0, frame count 0, last interval 4; no result pending.
`default_nettype none
module stepper_error_tracking_stepper
  import setrk_pkg::*;
(
  input  wire          clk_i,
  input  wire          rst_ni,
  setrk_in_if.sink     in_ch,
  setrk_out_if.source  out_ch,
  setrk_cfg_if.sink    cfg_ch
);

  // Sequencer states
  typedef enum logic [2:0] {
    S_IDLE,   // waiting for a tick word
    S_MAG,    // frame reset, error magnitude
    S_EVAL,   // idle/limit decision, product and divide setup
    S_DIV,    // one quotient bit per cycle
    S_STEP,   // due test and phase advance
    S_OUT     // load result register
  } state_e;

  state_e state_q;

  // Configuration registers
  logic        err_sel_q;
  logic        invert_q;
  logic [14:0] deadband_q;
  logic [15:0] max_err_q;
  logic [15:0] min_int_q;
  logic [15:0] max_int_q;
  logic [7:0]  frame_lim_q;

  // Axis state
  logic [2:0]  phase_q;
  logic [31:0] next_time_q;
  logic [7:0]  frame_steps_q;
  logic [15:0] last_int_q;
  logic        energized_q;

  // Per-tick work registers
  logic [31:0] now_q;
  logic        tracking_q;
  logic        fresh_q;
  logic [15:0] raw_q;
  logic        neg_q;
  logic [16:0] mag_q;
  logic        fast_q;      // error at or past max_error: use min interval
  logic        stepped_q;
  logic        back_q;

  // Divider: remainder, dividend low half shifting into quotient
  logic [15:0]        rem_q;
  logic [15:0]        quo_q;
  logic [15:0]        divisor_q;
  logic [DivCntW-1:0] div_cnt_q;

  out_word_t out_q;
  logic      out_valid_q;

  // Magnitude; the most negative error maps to 32768
  logic [16:0] mag_w;
  assign mag_w = raw_q[15] ? (17'h10000 - {1'b0, raw_q}) : {1'b0, raw_q};

  logic        idle_w;
  logic        limit_w;
  logic [15:0] span_w;
  logic [16:0] excess_w;
  logic [31:0] prod_w;
  assign idle_w   = !tracking_q || (mag_q <= {2'b00, deadband_q});
  assign limit_w  = frame_steps_q >= frame_lim_q;
  assign span_w   = (max_int_q > min_int_q) ? (max_int_q - min_int_q) : 16'd0;
  assign excess_w = mag_q - {2'b00, deadband_q};
  // Under interpolation excess <= 32768, so the product stays below 2^31
  assign prod_w   = {15'b0, excess_w} * {16'b0, span_w};

  // Restoring divide step; remainder stays below the 16-bit divisor
  logic [16:0] trial_w;
  logic        fits_w;
  assign trial_w = {rem_q, quo_q[15]};
  assign fits_w  = trial_w >= {1'b0, divisor_q};

  logic [15:0] interval_w;
  logic        due_w;
  logic [31:0] since_w;
  assign interval_w = fast_q ? min_int_q : (max_int_q - quo_q);
  assign since_w    = now_q - next_time_q;
  assign due_w      = !since_w[31];

  assign in_ch.ready  = (state_q == S_IDLE);
  assign cfg_ch.ready = 1'b1;
  assign out_ch.valid = out_valid_q;
  assign out_ch.data  = out_q;

  // Payload of the work and result registers; no reset needed
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      S_IDLE: begin
        if (in_ch.valid) begin
          now_q      <= in_ch.data.now_ms;
          tracking_q <= in_ch.data.tracking_on;
          fresh_q    <= in_ch.data.new_frame;
          raw_q      <= err_sel_q ? in_ch.data.pitch_error : in_ch.data.yaw_error;
        end
      end
      S_MAG: begin
        mag_q     <= mag_w;
        neg_q     <= raw_q[15];
        stepped_q <= 1'b0;
        back_q    <= 1'b0;
      end
      S_EVAL: begin
        fast_q    <= mag_q >= {1'b0, max_err_q};
        rem_q     <= prod_w[31:16];
        quo_q     <= prod_w[15:0];
        divisor_q <= max_err_q - {1'b0, deadband_q};
        div_cnt_q <= '0;
      end
      S_DIV: begin
        rem_q     <= fits_w ? 16'(trial_w - {1'b0, divisor_q}) : trial_w[15:0];
        quo_q     <= {quo_q[14:0], fits_w};
        div_cnt_q <= div_cnt_q + DivCntW'(1);
      end
      S_STEP: begin
        if (due_w) begin
          stepped_q <= 1'b1;
          back_q    <= !(neg_q ^ invert_q);
        end
      end
      S_OUT: begin
        if (!out_valid_q || out_ch.ready) begin
          out_q.coil_pattern  <= energized_q ? coil_of_phase(phase_q) : 4'h0;
          out_q.stepped       <= stepped_q;
          out_q.step_backward <= back_q;
          out_q.interval_ms   <= last_int_q;
        end
      end
      default: ;
    endcase
  end

  // Sequencer, configuration and axis state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= S_IDLE;
      out_valid_q   <= 1'b0;
      err_sel_q     <= 1'b0;
      invert_q      <= 1'b0;
      deadband_q    <= 15'd6;
      max_err_q     <= 16'd300;
      min_int_q     <= 16'd1;
      max_int_q     <= 16'd4;
      frame_lim_q   <= 8'd24;
      phase_q       <= 3'd0;
      next_time_q   <= 32'd0;
      frame_steps_q <= 8'd0;
      last_int_q    <= 16'd4;
      energized_q   <= 1'b0;
    end else begin
      if (cfg_ch.valid) begin
        unique case (cfg_ch.data.addr)
          CFG_ERROR_COMPONENT:  err_sel_q   <= cfg_ch.data.wdata[0];
          CFG_INVERT_RESPONSE:  invert_q    <= cfg_ch.data.wdata[0];
          CFG_DEADBAND:         deadband_q  <= cfg_ch.data.wdata[14:0];
          CFG_MAX_ERROR:        max_err_q   <= cfg_ch.data.wdata;
          CFG_MIN_INTERVAL_MS:  min_int_q   <= cfg_ch.data.wdata;
          CFG_MAX_INTERVAL_MS:  max_int_q   <= cfg_ch.data.wdata;
          CFG_FRAME_STEP_LIMIT: frame_lim_q <= cfg_ch.data.wdata[7:0];
          default: ;  // index past the list: ignored
        endcase
      end

      if (out_valid_q && out_ch.ready) begin
        out_valid_q <= 1'b0;
      end

      unique case (state_q)
        S_IDLE: begin
          if (in_ch.valid) begin
            state_q <= S_MAG;
          end
        end
        S_MAG: begin
          // New frame restarts the per-frame count and makes a step due now
          if (fresh_q) begin
            frame_steps_q <= 8'd0;
            next_time_q   <= now_q;
          end
          state_q <= S_EVAL;
        end
        S_EVAL: begin
          priority if (idle_w) begin
            last_int_q  <= max_int_q;
            next_time_q <= now_q + {16'b0, max_int_q};
            state_q     <= S_OUT;
          end else if (limit_w) begin
            state_q <= S_OUT;
          end else if (mag_q >= {1'b0, max_err_q}) begin
            state_q <= S_STEP;
          end else begin
            state_q <= S_DIV;
          end
        end
        S_DIV: begin
          if (div_cnt_q == DivCntW'(DivSteps - 1)) begin
            state_q <= S_STEP;
          end
        end
        S_STEP: begin
          last_int_q <= interval_w;
          if (due_w) begin
            // forward when the error sign and the response sign differ
            phase_q       <= (neg_q ^ invert_q) ? phase_q + 3'd1 : phase_q - 3'd1;
            energized_q   <= 1'b1;
            frame_steps_q <= frame_steps_q + 8'd1;
            next_time_q   <= now_q + {16'b0, interval_w};
          end
          state_q <= S_OUT;
        end
        S_OUT: begin
          if (!out_valid_q || out_ch.ready) begin
            out_valid_q <= 1'b1;
            state_q     <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // A backward step is always a step
  a_back_implies_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_ch.valid && out_ch.data.step_backward |-> out_ch.data.stepped)
    else $error("step_backward without stepped");

  // After a step the coils are driven
  a_step_drives_coils: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_ch.valid && out_ch.data.stepped |-> out_ch.data.coil_pattern != 4'h0)
    else $error("step reported with coils off");

  // Busy after taking a tick word
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ch.valid && in_ch.ready |=> !in_ch.ready)
    else $error("input ready while a tick is in work");

  // Divider runs only on an interpolated interval
  a_div_only_when_slow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_DIV |-> !fast_q && tracking_q)
    else $error("divide started on a non-interpolated tick");

endmodule
`default_nettype wire

### verif/stepper_error_tracking_stepper_tb.sv
// Testbench: drives ticks and register writes into the stepper axis and checks every result word.
module stepper_error_tracking_stepper_tb import setrk_pkg::*; ;
  timeunit 1ns;
  timeprecision 1ps;

  // Run limits. The slowest legal run is about 1900 words, each through the divide,
  // plus receiver stalls, sender gaps and the long hold; the cap is far above that.
  localparam int unsigned CycleLimit   = 800_000;
  localparam int unsigned SettleCycles = 25;   // a bit over the worst tick latency
  localparam int unsigned LongHold     = 400;  // receiver hold-off, long enough to back up the input
  localparam int unsigned ItemsPerSeg  = 300;
  localparam int unsigned BurstItems   = 40;

  // Index past the register file; the write must be dropped.
  localparam logic [2:0] CfgNoReg = 3'd7;

  // Half-step drive per phase, phase 0 in the low nibble.
  localparam logic [31:0] HalfStepCoils = {4'h9, 4'h8, 4'hC, 4'h4, 4'h6, 4'h2, 4'h3, 4'h1};

  typedef struct packed {
    logic        pitch_sel;
    logic        invert;
    logic [14:0] deadband;
    logic [15:0] max_error;
    logic [15:0] min_ivl;
    logic [15:0] max_ivl;
    logic [7:0]  frame_cap;
  } axis_cfg_t;

  typedef enum logic {ROW_REG, ROW_TICK} row_kind_e;

  // One row of the directed table: a register write or a tick, with the
  // result typed in where it is obvious.
  typedef struct packed {
    row_kind_e kind;
    cfg_word_t reg_wr;
    in_word_t  tick;
    logic      known;
    out_word_t want;
  } dir_row_t;

  logic clk;
  logic rst_n;

  setrk_in_if  tick_ch ();
  setrk_out_if res_ch ();
  setrk_cfg_if cfg_ch ();

  stepper_error_tracking_stepper dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .in_ch  (tick_ch),
    .out_ch (res_ch),
    .cfg_ch (cfg_ch)
  );

  // Axis model: register copy and stepping state.
  axis_cfg_t   ax_cfg;
  logic [2:0]  coil_phase;
  logic [31:0] next_due;
  logic [7:0]  frame_cnt;
  logic [15:0] last_ivl;
  logic        energized;

  out_word_t axis_result_q[$];  // expected result words, oldest first
  dir_row_t  directed_q[$];     // directed rows in flight, for typed-in results

  int unsigned fail_cnt    = 0;
  int unsigned cycle_cnt   = 0;
  int unsigned tx_idle_pct = 14;
  int unsigned rx_idle_pct = 84;
  int unsigned hold_req    = 0;
  int unsigned hold_ack    = 0;
  int unsigned hold_left   = 0;
  logic [31:0] clock_ms;        // stimulus millisecond clock
  axis_cfg_t   live_cfg;        // settings last written, used to shape stimulus

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  function automatic axis_cfg_t default_cfg();
    axis_cfg_t c;
    c.pitch_sel = 1'b0;
    c.invert    = 1'b0;
    c.deadband  = 15'd6;
    c.max_error = 16'd300;
    c.min_ivl   = 16'd1;
    c.max_ivl   = 16'd4;
    c.frame_cap = 8'd24;
    return c;
  endfunction

  function automatic void reset_axis();
    ax_cfg     = default_cfg();
    coil_phase = '0;
    next_due   = '0;
    frame_cnt  = '0;
    last_ivl   = 16'd4;
    energized  = 1'b0;
  endfunction

  function automatic void apply_reg(logic [2:0] idx, logic [15:0] val);
    case (idx)
      CFG_ERROR_COMPONENT:  ax_cfg.pitch_sel = val[0];
      CFG_INVERT_RESPONSE:  ax_cfg.invert    = val[0];
      CFG_DEADBAND:         ax_cfg.deadband  = val[14:0];
      CFG_MAX_ERROR:        ax_cfg.max_error = val;
      CFG_MIN_INTERVAL_MS:  ax_cfg.min_ivl   = val;
      CFG_MAX_INTERVAL_MS:  ax_cfg.max_ivl   = val;
      CFG_FRAME_STEP_LIMIT: ax_cfg.frame_cap = val[7:0];
      default: ;
    endcase
  endfunction

  // Works out the result word of one tick and moves the axis state on.
  function automatic out_word_t predict_axis(in_word_t t);
    logic [15:0] raw;
    logic        neg;
    logic [31:0] mag;
    logic [31:0] span;
    logic [31:0] scaled;
    logic [31:0] lapse;
    logic [15:0] ivl;
    out_word_t   r;
    r = '0;
    // a fresh frame rearms the step budget and makes a step due right away
    if (t.new_frame) begin
      frame_cnt = '0;
      next_due  = t.now_ms;
    end
    raw = ax_cfg.pitch_sel ? t.pitch_error : t.yaw_error;
    neg = raw[15];
    mag = neg ? 32'h1_0000 - 32'(raw) : 32'(raw);   // -32768 gives 32768
    if (!t.tracking_on || mag <= 32'(ax_cfg.deadband)) begin
      last_ivl = ax_cfg.max_ivl;
      next_due = t.now_ms + 32'(ax_cfg.max_ivl);
    end else if (frame_cnt < ax_cfg.frame_cap) begin
      if (mag >= 32'(ax_cfg.max_error)) begin
        ivl = ax_cfg.min_ivl;
      end else begin
        // min above max collapses the span, so the interval stays at max
        span   = (ax_cfg.max_ivl > ax_cfg.min_ivl) ?
                 32'(ax_cfg.max_ivl - ax_cfg.min_ivl) : '0;
        scaled = (mag - 32'(ax_cfg.deadband)) * span /
                 (32'(ax_cfg.max_error) - 32'(ax_cfg.deadband));
        ivl    = ax_cfg.max_ivl - scaled[15:0];
      end
      last_ivl = ivl;
      // due when the wrapped difference is not negative
      lapse = t.now_ms - next_due;
      if (!lapse[31]) begin
        if (neg ^ ax_cfg.invert) begin
          coil_phase = coil_phase + 3'd1;
        end else begin
          coil_phase      = coil_phase - 3'd1;
          r.step_backward = 1'b1;
        end
        energized = 1'b1;
        frame_cnt = frame_cnt + 8'd1;
        next_due  = t.now_ms + 32'(ivl);
        r.stepped = 1'b1;
      end
    end
    r.coil_pattern = energized ? HalfStepCoils[{coil_phase, 2'b00} +: 4] : 4'h0;
    r.interval_ms  = last_ivl;
    return r;
  endfunction

  // Watchdog.
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CycleLimit) begin
      $error("timeout after %0d cycles, %0d results outstanding", cycle_cnt,
             axis_result_q.size());
      $display("stepper_error_tracking_stepper_tb: FAIL");
      $finish;
    end
  end

  // Result sink: random stalls, plus a long hold-off whenever one is requested.
  always @(posedge clk) begin
    if (hold_req != hold_ack) begin
      hold_ack     <= hold_req;
      hold_left    <= LongHold;
      res_ch.ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left    <= hold_left - 1;
      res_ch.ready <= 1'b0;
    end else begin
      res_ch.ready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  // Monitor: everything is sampled at the rising edge, before any driver update lands.
  // Results are checked first, then register writes and ticks update the model.
  always @(posedge clk) begin : monitor
    out_word_t got;
    out_word_t want;
    dir_row_t  row;
    if (rst_n) begin
      if (res_ch.valid && res_ch.ready) begin
        got = res_ch.data;
        if (axis_result_q.size() == 0) begin
          $error("result word with nothing expected: %p", got);
          fail_cnt++;
        end else begin
          want = axis_result_q.pop_front();
          if (got.coil_pattern !== want.coil_pattern) begin
            $error("coil_pattern: expected %h, got %h", want.coil_pattern, got.coil_pattern);
            fail_cnt++;
          end
          if (got.stepped !== want.stepped) begin
            $error("stepped: expected %b, got %b", want.stepped, got.stepped);
            fail_cnt++;
          end
          if (got.step_backward !== want.step_backward) begin
            $error("step_backward: expected %b, got %b", want.step_backward,
                   got.step_backward);
            fail_cnt++;
          end
          if (got.interval_ms !== want.interval_ms) begin
            $error("interval_ms: expected %0d, got %0d", want.interval_ms, got.interval_ms);
            fail_cnt++;
          end
        end
      end
      if (cfg_ch.valid && cfg_ch.ready) begin
        apply_reg(cfg_ch.data.addr, cfg_ch.data.wdata);
      end
      if (tick_ch.valid && tick_ch.ready) begin
        want = predict_axis(tick_ch.data);
        // directed rows with a typed-in result override the model's word
        if (directed_q.size() != 0) begin
          row = directed_q.pop_front();
          if (row.known) begin
            want = row.want;
          end
        end
        axis_result_q.push_back(want);
      end
    end
  end

  function automatic bit coin();
    return bit'($urandom_range(1));
  endfunction

  // Offers one tick and waits for it to be taken. Valid is left high so that
  // back-to-back words need no second assignment in the same step; idle
  // cycles are drawn per cycle afterwards.
  task automatic send_tick(in_word_t w);
    tick_ch.valid <= 1'b1;
    tick_ch.data  <= w;
    do @(posedge clk); while (!tick_ch.ready);
    while ($urandom_range(99) < tx_idle_pct) begin
      tick_ch.valid <= 1'b0;
      @(posedge clk);
    end
  endtask

  // Stops offering and waits until every expected word is back, then lets
  // the pipeline settle.
  task automatic drain_axis();
    tick_ch.valid <= 1'b0;
    do @(posedge clk); while (axis_result_q.size() != 0);
    repeat (SettleCycles) @(posedge clk);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [15:0] val);
    cfg_ch.valid <= 1'b1;
    cfg_ch.data  <= '{addr: idx, wdata: val};
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic write_config(axis_cfg_t c);
    write_reg(CFG_ERROR_COMPONENT, 16'(c.pitch_sel));
    write_reg(CFG_INVERT_RESPONSE, 16'(c.invert));
    write_reg(CFG_DEADBAND, 16'(c.deadband));
    write_reg(CFG_MAX_ERROR, c.max_error);
    write_reg(CFG_MIN_INTERVAL_MS, c.min_ivl);
    write_reg(CFG_MAX_INTERVAL_MS, c.max_ivl);
    write_reg(CFG_FRAME_STEP_LIMIT, 16'(c.frame_cap));
    live_cfg = c;
  endtask

  // Working settings; the wild flavor pushes each register to an end of its range half the time.
  function automatic axis_cfg_t pick_profile(bit wild);
    axis_cfg_t   c;
    int unsigned me;
    c.pitch_sel = coin();
    c.invert    = coin();
    c.deadband  = (wild && coin()) ? (coin() ? 15'h7FFF : 15'h0) : 15'($urandom_range(40));
    me = c.deadband + $urandom_range(1, 2000);
    if (me > 32768) me = 32768;
    c.max_error = (wild && coin()) ? (coin() ? 16'h8000 : 16'h0) : 16'(me);
    c.min_ivl   = (wild && coin()) ? (coin() ? 16'hFFFF : 16'h0) : 16'($urandom_range(4));
    c.max_ivl   = (wild && coin()) ? (coin() ? 16'hFFFF : 16'h0) : 16'($urandom_range(24));
    c.frame_cap = (wild && coin()) ? (coin() ? 8'hFF : 8'h0) : 8'($urandom_range(1, 40));
    return c;
  endfunction

  // Mostly ticks one millisecond apart with errors around the deadband and
  // speed range; some jumps in time, and some words of pure noise.
  function automatic in_word_t random_tick(axis_cfg_t c);
    in_word_t    t;
    int unsigned r;
    int unsigned lim;
    int unsigned mag;
    logic [15:0] err;
    logic        neg;
    if ($urandom_range(99) < 15) begin
      t.now_ms      = $urandom;
      t.yaw_error   = 16'($urandom);
      t.pitch_error = 16'($urandom);
      t.tracking_on = coin();
      t.new_frame   = coin();
      return t;
    end
    r = $urandom_range(99);
    clock_ms += (r < 85) ? 32'd1 : (r < 93) ? 32'd0 : 32'($urandom_range(2, 60));
    r = $urandom_range(99);
    if (r < 30) lim = c.deadband + 2;
    else if (r < 80) lim = c.max_error + 20;
    else lim = 32768;
    if (lim > 32768) lim = 32768;
    mag = $urandom_range(lim);
    neg = coin();
    if (!neg && mag == 32768) mag = 32767;
    err = neg ? 16'(-int'(mag)) : 16'(mag);
    t.now_ms      = clock_ms;
    t.tracking_on = ($urandom_range(99) < 90);
    t.new_frame   = ($urandom_range(99) < 8);
    if (c.pitch_sel) begin
      t.pitch_error = err;
      t.yaw_error   = 16'($urandom);
    end else begin
      t.yaw_error   = err;
      t.pitch_error = 16'($urandom);
    end
    return t;
  endfunction

  function automatic dir_row_t tick_row(logic [31:0] now, logic [15:0] yaw, logic [15:0] pitch,
                                        logic trk, logic nf, logic known = 1'b0,
                                        out_word_t want = '0);
    dir_row_t r;
    r        = '0;
    r.kind   = ROW_TICK;
    r.tick   = '{now_ms: now, yaw_error: yaw, pitch_error: pitch,
                 tracking_on: trk, new_frame: nf};
    r.known  = known;
    r.want   = want;
    return r;
  endfunction

  function automatic dir_row_t reg_row(logic [2:0] idx, logic [15:0] val);
    dir_row_t r;
    r        = '0;
    r.kind   = ROW_REG;
    r.reg_wr = '{addr: idx, wdata: val};
    return r;
  endfunction

  initial begin : stimulus
    dir_row_t plan[$];
    tick_ch.valid = 1'b0;
    tick_ch.data  = '0;
    res_ch.ready  = 1'b0;
    cfg_ch.valid  = 1'b0;
    cfg_ch.data   = '0;
    rst_n         = 1'b0;
    clock_ms      = '0;
    reset_axis();
    live_cfg = default_cfg();

    // Reset settings: idle word, fast step back on a large positive error,
    // forward on the most negative error, then a tick that is not yet due.
    plan.push_back(tick_row(32'd0, 16'd0, 16'd0, 1'b0, 1'b0, 1'b1,
                   '{coil_pattern: 4'h0, stepped: 1'b0, step_backward: 1'b0,
                     interval_ms: 16'd4}));
    plan.push_back(tick_row(32'd100, 16'h7FFF, 16'h8000, 1'b1, 1'b1, 1'b1,
                   '{coil_pattern: 4'h9, stepped: 1'b1, step_backward: 1'b1,
                     interval_ms: 16'd1}));
    plan.push_back(tick_row(32'd101, 16'h8000, 16'h7FFF, 1'b1, 1'b0, 1'b1,
                   '{coil_pattern: 4'h1, stepped: 1'b1, step_backward: 1'b0,
                     interval_ms: 16'd1}));
    plan.push_back(tick_row(32'd101, 16'h8000, 16'h0, 1'b1, 1'b0, 1'b1,
                   '{coil_pattern: 4'h1, stepped: 1'b0, step_backward: 1'b0,
                     interval_ms: 16'd1}));
    // interpolated interval across the time wrap, deadband edge and one past it
    plan.push_back(tick_row(32'hFFFF_FFFF, 16'd150, 16'hFFFF, 1'b1, 1'b1));
    plan.push_back(tick_row(32'd2, 16'd150, 16'd0, 1'b1, 1'b0));
    plan.push_back(tick_row(32'd3, 16'd6, 16'd0, 1'b1, 1'b0));
    plan.push_back(tick_row(32'd4, -16'sd7, 16'd0, 1'b1, 1'b1));
    // pitch selected and response inverted
    plan.push_back(reg_row(CFG_ERROR_COMPONENT, 16'd1));
    plan.push_back(reg_row(CFG_INVERT_RESPONSE, 16'd1));
    plan.push_back(tick_row(32'd10, 16'h7FFF, -16'sd200, 1'b1, 1'b1));
    plan.push_back(tick_row(32'd11, 16'd0, 16'd200, 1'b1, 1'b0));
    // widest deadband and error scale, interval range at its ends
    plan.push_back(reg_row(CFG_DEADBAND, 16'h7FFF));
    plan.push_back(reg_row(CFG_MAX_ERROR, 16'h8000));
    plan.push_back(reg_row(CFG_MIN_INTERVAL_MS, 16'h0));
    plan.push_back(reg_row(CFG_MAX_INTERVAL_MS, 16'hFFFF));
    plan.push_back(tick_row(32'd20, 16'd0, 16'h8000, 1'b1, 1'b1));
    plan.push_back(tick_row(32'd20, 16'd0, 16'h7FFF, 1'b1, 1'b0));
    plan.push_back(tick_row(32'd21, 16'd0, 16'h8000, 1'b0, 1'b0));
    // zero deadband and zero error scale
    plan.push_back(reg_row(CFG_DEADBAND, 16'h0));
    plan.push_back(reg_row(CFG_MAX_ERROR, 16'h0));
    plan.push_back(tick_row(32'd30, 16'd0, 16'd0, 1'b1, 1'b1));
    plan.push_back(tick_row(32'd30, 16'd0, 16'd1, 1'b1, 1'b1));
    // min above max, and a cap of two steps per frame
    plan.push_back(reg_row(CFG_MIN_INTERVAL_MS, 16'hFFFF));
    plan.push_back(reg_row(CFG_MAX_INTERVAL_MS, 16'h0));
    plan.push_back(reg_row(CFG_DEADBAND, 16'd10));
    plan.push_back(reg_row(CFG_MAX_ERROR, 16'd1000));
    plan.push_back(reg_row(CFG_FRAME_STEP_LIMIT, 16'd2));
    plan.push_back(tick_row(32'd50, 16'd0, 16'd500, 1'b1, 1'b1));
    plan.push_back(tick_row(32'd50, 16'd0, 16'd500, 1'b1, 1'b0));
    plan.push_back(tick_row(32'd51, 16'd0, 16'd500, 1'b1, 1'b0));
    plan.push_back(tick_row(32'd52, 16'd0, -16'sd500, 1'b1, 1'b1));
    // zero cap, then a write to a missing register that must change nothing
    plan.push_back(reg_row(CFG_FRAME_STEP_LIMIT, 16'h0));
    plan.push_back(reg_row(CfgNoReg, 16'hFFFF));
    plan.push_back(tick_row(32'd60, 16'd0, 16'd500, 1'b1, 1'b1));
    plan.push_back(tick_row(32'd61, 16'd0, 16'd500, 1'b0, 1'b1));

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // Directed table: registers are only written with nothing in flight.
    foreach (plan[i]) begin
      if (plan[i].kind == ROW_REG) begin
        drain_axis();
        write_reg(plan[i].reg_wr.addr, plan[i].reg_wr.wdata);
      end else begin
        directed_q.push_back(plan[i]);
        send_tick(plan[i].tick);
      end
    end

    // Random part: three idling regimes, two settings each (working, then wild).
    for (int ph = 0; ph < 3; ph++) begin
      tx_idle_pct  = (ph == 0) ? 14 : (ph == 1) ? 84 : 0;
      rx_idle_pct <= (ph == 0) ? 84 : (ph == 1) ? 14 : 0;
      for (int seg = 0; seg < 2; seg++) begin
        drain_axis();
        write_config(pick_profile(seg == 1));
        clock_ms = coin() ? $urandom : 32'hFFFF_FF00;
        if (ph == 2 && seg == 0) begin
          // sink holds off while ticks keep coming, so the block backs up
          // and stalls its input; then the sender waits for the backlog
          hold_req <= hold_req + 1;
          repeat (BurstItems) send_tick(random_tick(live_cfg));
          drain_axis();
        end
        repeat (ItemsPerSeg) send_tick(random_tick(live_cfg));
      end
    end

    drain_axis();
    if (fail_cnt == 0) begin
      $display("stepper_error_tracking_stepper_tb: PASS");
    end else begin
      $display("stepper_error_tracking_stepper_tb: FAIL");
    end
    $finish;
  end

endmodule

### sim.f
design/setrk_pkg.sv
design/setrk_in_if.sv
design/setrk_out_if.sv
design/setrk_cfg_if.sv
design/stepper_error_tracking_stepper.sv
verif/stepper_error_tracking_stepper_tb.sv
